[rtl/astar_shortest_path_defines.svh]
// Assertion macros shared by the checker.
`ifndef ASTAR_SHORTEST_PATH_DEFINES_SVH
`define ASTAR_SHORTEST_PATH_DEFINES_SVH
// Same-cycle implication.
`define AST_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("label failed");
// Next-cycle implication.
`define AST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("label failed");
`endif

[rtl/astar_pkg.sv]
package astar_pkg;
  localparam int MAX_NODES_DEF   = 16;
  localparam int MAX_EDGES_DEF   = 64;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int NODE_W = 4;
  localparam int COST_W = 20;
  localparam int HEUR_W = 16;
  localparam int PATH_DEPTH = 16;
  localparam logic [COST_W-1:0] COST_INF = 20'hFFFFF;

  localparam logic [1:0] OP_SET_H  = 2'd0;
  localparam logic [1:0] OP_ADD_E  = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [15:0]       value;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [NODE_W-1:0] path_node;
    logic [COST_W-1:0] path_cost;
    logic              edges_dropped;
    logic              last;
  } res_t;

  typedef struct packed {
    logic take;
    logic ld_h;
    logic ld_e;
    logic clr_e;
    logic init;
    logic sel_clr;
    logic sel_next;
    logic sel_rd;
    logic sel_cmp;
    logic pop;
    logic edge_chk;
    logic relax;
    logic walk_init;
    logic walk_push;
    logic walk_next;
    logic out_init;
    logic out_emit;
    logic emit_nf;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic open_i;
    logic sel_last;
    logic any;
    logic u_goal;
    logic e_done;
    logic incident;
    logic walk_stop;
    logic p_zero;
  } stat_t;
endpackage

[rtl/astar_ram.sv]
module astar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/astar_ctrl.sv]
module astar_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         opcode,
  input  astar_pkg::stat_t   st,
  output astar_pkg::cmd_t    cmd,
  output logic               busy
);
  import astar_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_INIT  = 16'h0002,
    S_SEL0  = 16'h0004,
    S_SCAN  = 16'h0008,
    S_CMP   = 16'h0010,
    S_POP   = 16'h0020,
    S_EDGE  = 16'h0040,
    S_ECHK  = 16'h0080,
    S_RCMP  = 16'h0100,
    S_WALK0 = 16'h0200,
    S_WPUSH = 16'h0400,
    S_WNEXT = 16'h0800,
    S_OUT0  = 16'h1000,
    S_OUTRD = 16'h2000,
    S_OUTEM = 16'h4000,
    S_NF    = 16'h8000
  } state_t;

  state_t state, state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.take = 1'b1;
          case (opcode)
            OP_SET_H:  cmd.ld_h = 1'b1;
            OP_ADD_E:  cmd.ld_e = 1'b1;
            OP_SEARCH: state_next = S_INIT;
            OP_CLEAR:  cmd.clr_e = 1'b1;
            default:   cmd.clr_e = 1'b1;
          endcase
        end
      end
      S_INIT: begin
        if (st.bad) begin
          state_next = S_NF;
        end else begin
          cmd.init = 1'b1;
          state_next = S_SEL0;
        end
      end
      S_SEL0: begin
        cmd.sel_clr = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (st.open_i) begin
          cmd.sel_rd = 1'b1;
          state_next = S_CMP;
        end else if (st.sel_last) begin
          state_next = st.any ? S_POP : S_NF;
        end else begin
          cmd.sel_next = 1'b1;
        end
      end
      S_CMP: begin
        cmd.sel_cmp = 1'b1;
        if (st.sel_last) begin
          state_next = S_POP;
        end else begin
          cmd.sel_next = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_POP: begin
        cmd.pop = 1'b1;
        state_next = st.u_goal ? S_WALK0 : S_EDGE;
      end
      S_EDGE: begin
        state_next = st.e_done ? S_SEL0 : S_ECHK;
      end
      S_ECHK: begin
        cmd.edge_chk = 1'b1;
        state_next = st.incident ? S_RCMP : S_EDGE;
      end
      S_RCMP: begin
        cmd.relax = 1'b1;
        state_next = S_EDGE;
      end
      S_WALK0: begin
        cmd.walk_init = 1'b1;
        state_next = S_WPUSH;
      end
      S_WPUSH: begin
        cmd.walk_push = 1'b1;
        state_next = st.walk_stop ? S_OUT0 : S_WNEXT;
      end
      S_WNEXT: begin
        cmd.walk_next = 1'b1;
        state_next = S_WPUSH;
      end
      S_OUT0: begin
        cmd.out_init = 1'b1;
        state_next = S_OUTRD;
      end
      S_OUTRD: begin
        state_next = S_OUTEM;
      end
      S_OUTEM: begin
        cmd.out_emit = 1'b1;
        state_next = st.p_zero ? S_IDLE : S_OUTRD;
      end
      S_NF: begin
        cmd.emit_nf = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

[rtl/astar_dp.sv]
module astar_dp #(
  parameter int MAX_NODES   = astar_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES   = astar_pkg::MAX_EDGES_DEF,
  parameter int WEIGHT_BITS = astar_pkg::WEIGHT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  astar_pkg::req_t  request,
  input  astar_pkg::cmd_t  cmd,
  output astar_pkg::stat_t st,
  output astar_pkg::res_t  result,
  output logic             result_strobe
);
  import astar_pkg::*;

  localparam int NODES = (MAX_NODES < 16) ? MAX_NODES : 16;
  localparam int IW = $clog2(NODES);
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int ED_W = 2 * NODE_W + WEIGHT_BITS;
  localparam int SW = ((WEIGHT_BITS > COST_W) ? WEIGHT_BITS : COST_W) + 1;

  // edge table
  logic [CW-1:0] edge_count, e;
  logic          overflow;
  logic [WEIGHT_BITS-1:0] wval;
  logic [ED_W-1:0] e_rd;
  logic a_ok, b_ok;

  // search state
  logic [HEUR_W-1:0] heur [NODES];
  logic [NODES-1:0]  open, vis, has;
  logic [NODE_W-1:0] sn, gn, u, wv;
  logic [IW-1:0]     idx, v;
  logic [COST_W-1:0] bu;
  logic [COST_W:0]   bf;
  logic              any;
  logic [WEIGHT_BITS-1:0] w;
  logic [4:0]        len;
  logic [3:0]        p;

  // memory ports
  logic [COST_W-1:0] b_rd, b_wd, cur;
  logic [IW-1:0]     b_wa, b_ra;
  logic              b_we, rvis;
  logic [NODE_W-1:0] pr_rd, st_rd;

  // incident edge decode
  logic [NODE_W-1:0] ea, eb, en;
  logic [WEIGHT_BITS-1:0] ew;
  logic              inc;
  logic [COST_W:0]   f;
  logic [SW-1:0]     tmp;
  logic              better;

  always_comb begin
    for (int i = 0; i < WEIGHT_BITS; i++) begin
      wval[i] = (i < 16) ? request.value[i] : 1'b0;
    end
  end

  assign a_ok = 32'(request.node_a) < MAX_NODES;
  assign b_ok = 32'(request.node_b) < MAX_NODES;

  assign ea = e_rd[ED_W-1 -: NODE_W];
  assign eb = e_rd[WEIGHT_BITS +: NODE_W];
  assign ew = e_rd[WEIGHT_BITS-1:0];
  assign inc = (ea == u) || (eb == u);
  assign en = (ea == u) ? eb : ea;

  assign cur = rvis ? b_rd : COST_INF;
  assign f = {1'b0, cur} + {{(COST_W + 1 - HEUR_W){1'b0}}, heur[idx]};
  assign tmp = SW'(bu) + SW'(w);
  assign better = tmp < SW'(cur);

  assign b_ra = cmd.sel_rd ? idx : en[IW-1:0];
  assign b_we = cmd.init || (cmd.relax && better);
  assign b_wa = cmd.init ? sn[IW-1:0] : v;
  assign b_wd = cmd.init ? '0 : tmp[COST_W-1:0];

  assign st.bad = !(32'(sn) < MAX_NODES) || !(32'(gn) < MAX_NODES);
  assign st.open_i = open[idx];
  assign st.sel_last = (idx == IW'(NODES - 1));
  assign st.any = any;
  assign st.u_goal = (u == gn);
  assign st.e_done = (e >= edge_count);
  assign st.incident = inc;
  assign st.walk_stop = (wv == sn) || !has[wv[IW-1:0]] || (len >= 5'd15);
  assign st.p_zero = (p == 4'd0);

  astar_ram #(.WIDTH(ED_W), .DEPTH(MAX_EDGES)) u_edge (
    .clk, .we(cmd.ld_e && a_ok && b_ok && (edge_count < CW'(MAX_EDGES))),
    .waddr(edge_count[EW-1:0]),
    .wdata({request.node_a, request.node_b, wval}),
    .raddr(e[EW-1:0]), .rdata(e_rd)
  );

  astar_ram #(.WIDTH(COST_W), .DEPTH(NODES)) u_best (
    .clk, .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd)
  );

  astar_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_pred (
    .clk, .we(cmd.relax && better), .waddr(v), .wdata(u),
    .raddr(wv[IW-1:0]), .rdata(pr_rd)
  );

  astar_ram #(.WIDTH(NODE_W), .DEPTH(PATH_DEPTH)) u_stack (
    .clk, .we(cmd.walk_push), .waddr(len[3:0]), .wdata(wv),
    .raddr(p), .rdata(st_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count <= '0;
      overflow <= 1'b0;
      result_strobe <= 1'b0;
      for (int i = 0; i < NODES; i++) begin
        heur[i] <= '0;
      end
    end else begin
      result_strobe <= cmd.out_emit || cmd.emit_nf;
      if (cmd.ld_h && a_ok) begin
        heur[request.node_a[IW-1:0]] <= request.value;
      end
      if (cmd.ld_e && a_ok && b_ok) begin
        if (edge_count < CW'(MAX_EDGES)) begin
          edge_count <= edge_count + 1'b1;
        end else begin
          overflow <= 1'b1;
        end
      end
      if (cmd.clr_e) begin
        edge_count <= '0;
        overflow <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rvis <= vis[b_ra];
    if (cmd.take) begin
      sn <= request.node_a;
      gn <= request.node_b;
    end
    if (cmd.init) begin
      // only the start node is open and holds a cost
      open <= NODES'(1) << sn[IW-1:0];
      vis <= NODES'(1) << sn[IW-1:0];
      has <= '0;
    end
    if (cmd.sel_clr) begin
      idx <= '0;
      any <= 1'b0;
    end
    if (cmd.sel_next) begin
      idx <= idx + 1'b1;
    end
    if (cmd.sel_cmp && (!any || f < bf)) begin
      // strict compare in ascending order: ties keep the lower node
      any <= 1'b1;
      bf <= f;
      u <= NODE_W'(idx);
      bu <= cur;
    end
    if (cmd.pop) begin
      open[u[IW-1:0]] <= 1'b0;
      e <= '0;
    end
    if (cmd.edge_chk) begin
      e <= e + 1'b1;
      v <= en[IW-1:0];
      w <= ew;
    end
    if (cmd.relax && better) begin
      open[v] <= 1'b1;
      vis[v] <= 1'b1;
      has[v] <= 1'b1;
    end
    if (cmd.walk_init) begin
      wv <= gn;
      len <= '0;
    end
    if (cmd.walk_push) begin
      len <= len + 1'b1;
    end
    if (cmd.walk_next) begin
      wv <= pr_rd;
    end
    if (cmd.out_init) begin
      p <= 4'(len - 5'd1);
    end
    if (cmd.out_emit) begin
      p <= p - 1'b1;
    end
    if (cmd.out_emit) begin
      result.found <= 1'b1;
      result.path_node <= st_rd;
      result.path_cost <= bu;
      result.edges_dropped <= overflow;
      result.last <= (p == 4'd0);
    end
    if (cmd.emit_nf) begin
      result.found <= 1'b0;
      result.path_node <= '0;
      result.path_cost <= COST_INF;
      result.edges_dropped <= overflow;
      result.last <= 1'b1;
    end
  end
endmodule

[rtl/astar_shortest_path.sv]
// A* shortest-path engine over a small undirected weighted graph.
// Input channel: request is taken at a rising edge with start high and busy
//   low. Opcodes: set heuristic, add edge, run search, clear edge table.
// Loads and clear finish in the accepting cycle; busy stays low and no
//   result is produced. An edge past MAX_EDGES is dropped and sets the
//   edges_dropped flag until the next clear.
// A search raises busy and produces one result per path node, start first,
//   each valid for one cycle with result_strobe high, last on the final one;
//   or a single not-found result. The receiver cannot stall the block.
// Each expansion scans the open set (reading the cost of each open node)
//   and then the edge table (reading the cost of each edge's far node when
//   the edge touches the expanded node), all through the one read port of
//   the cost memory. The path is then walked back from the goal node, and
//   busy drops in the cycle of the last strobe.
// Reset (rst, synchronous): heuristics cleared to zero, edge table emptied,
//   flag cleared, controller idle.
module astar_shortest_path #(
  parameter int MAX_NODES   = astar_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES   = astar_pkg::MAX_EDGES_DEF,
  parameter int WEIGHT_BITS = astar_pkg::WEIGHT_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  astar_pkg::req_t request,
  output astar_pkg::res_t result,
  output logic            result_strobe
);
  import astar_pkg::*;

  cmd_t  cmd;   // controller -> datapath
  stat_t st;    // datapath -> controller

  // sequencer: decides loads, selection scan, edge scan, path walk, output
  astar_ctrl u_ctrl (
    .clk, .rst, .start, .opcode(request.opcode), .st, .cmd, .busy
  );

  // tables, cost memory, open set and result register
  astar_dp #(
    .MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES), .WEIGHT_BITS(WEIGHT_BITS)
  ) u_dp (
    .clk, .rst, .request, .cmd, .st, .result, .result_strobe
  );
endmodule

[rtl/astar_chk.sv]
`include "astar_shortest_path_defines.svh"
module astar_chk (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input astar_pkg::req_t request,
  input astar_pkg::res_t result,
  input logic            result_strobe
);
  import astar_pkg::*;

  // busy drops exactly with the final item of a search
  `AST_NOW(a_last_idle, result_strobe, result.last == !busy)
  // not-found is a lone item with fixed fields
  `AST_NOW(a_nf_form, result_strobe && !result.found,
           result.last && result.path_cost == COST_INF && result.path_node == '0)
  // loads and clear complete at once
  `AST_NEXT(a_load_quick, start && !busy && request.opcode != OP_SEARCH,
            !busy && !result_strobe)
endmodule

bind astar_shortest_path astar_chk u_chk (.*);
